// File: hdl/rcsfr_pkg.sv
// Package for the RC serial frame receiver: byte codes, port widths,
// register indexes and the emission state type.
// No dependencies; used by rc_serial_frame_receiver.
`default_nettype none

package rcsfr_pkg;

	// Command byte that must follow the length byte of a frame header.
	localparam logic [7:0] CMD_BYTE = 8'h40;

	// Payload widths on the stream ports.
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned INDEX_W     = 4;
	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CFG_DATA_W  = 16;

	// Configuration register indexes.
	typedef enum logic {
		REG_MIN_VALUE = 1'b0,
		REG_MAX_VALUE = 1'b1
	} cfg_reg_t;

	// Result emission sequencer.
	typedef enum logic [1:0] {
		EM_IDLE,
		EM_LOAD,
		EM_SHOW
	} emit_state_t;

endpackage

`default_nettype wire

// File: hdl/rc_serial_frame_receiver.sv
// RC serial frame receiver: parses a byte stream into checked channel frames.
// Depends on rcsfr_pkg and rcsfr_ram.
//
// Usage: received serial bytes enter on the s_axis channel, one byte per beat.
// The parser hunts for the length byte FRAME_BYTES followed by the command
// byte 0x40, collects the frame, sums bytes 0..FRAME_BYTES-3 and writes each
// little-endian channel word into the channel RAM, checking it against the
// min/max registers as it arrives.
// On the final checksum byte of a good frame with all channels in range, the
// block sends CHANNELS beats on m_axis (index, value, tlast on the final one).
// A bad frame sends nothing. The burst is read from the channel RAM one word
// at a time; each result passes the RAM read register and then the output
// register, and the next word is read once the previous beat is taken.
// s_axis_tready is low while a burst is in flight, so a stalled sink holds
// the parser too; the output beat stays stable until taken.
// Reset clears the parser (hunting for a header), the emission sequencer and
// loads the limits 1000 and 2000. The channel RAM is not cleared.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none

module rc_serial_frame_receiver #(
	parameter int CHANNELS    = 14,
	parameter int FRAME_BYTES = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Configuration write port.
	input  wire logic                                  cfg_we,
	input  wire logic                                  cfg_index,
	input  wire logic [rcsfr_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input bytes. tdata: [7:0] data_byte.
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [rcsfr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Results. tdata: [3:0] channel_index, [19:4] channel_value, [23:20] zero.
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output logic [rcsfr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	output logic                                       m_axis_tlast
);

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW    = ((POS_W > CH_W) ? POS_W : CH_W) + 1;
	localparam int VW    = rcsfr_pkg::VALUE_W;

	// Configuration registers.
	logic [VW-1:0] min_q;
	logic [VW-1:0] max_q;

	// Parser state.
	logic [POS_W-1:0] pos_q;
	logic [VW-1:0]    sum_q;
	logic [7:0]       low_q;
	logic             fault_q;

	// Emission state.
	rcsfr_pkg::emit_state_t state_q, state_d;
	logic [CH_W-1:0]  idx_q;
	logic [VW-1:0]    value_q;

	// RAM ports.
	logic             ram_we;
	logic [CH_W-1:0]  ram_waddr;
	logic             ram_re;
	logic [CH_W-1:0]  ram_raddr;
	logic [VW-1:0]    ram_rdata;

	logic             in_beat;
	logic             out_beat;
	logic             idx_last;
	logic [7:0]       b;
	logic [VW-1:0]    word;
	logic [CW-1:0]    ch;
	logic             ch_ok;
	logic             word_bad;
	logic             pos_payload;
	logic             pos_last;
	logic             good_frame;

	assign b        = s_axis_tdata;
	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;
	assign idx_last = (idx_q == CH_W'(CHANNELS - 1));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= VW'(1000);
			max_q <= VW'(2000);
		end else if (cfg_we) begin
			unique case (rcsfr_pkg::cfg_reg_t'(cfg_index))
				rcsfr_pkg::REG_MIN_VALUE: min_q <= cfg_data;
				rcsfr_pkg::REG_MAX_VALUE: max_q <= cfg_data;
			endcase
		end
	end

	// Channel decode of the current byte position and the range check.
	assign word        = {b, low_q};
	assign ch          = (CW'(pos_q) - CW'(3)) >> 1;
	assign ch_ok       = (ch < CW'(CHANNELS));
	assign word_bad    = (word < min_q) || (word > max_q);
	assign pos_payload = (pos_q >= POS_W'(2)) && (pos_q < POS_W'(FRAME_BYTES - 2));
	assign pos_last    = (pos_q == POS_W'(FRAME_BYTES - 1));

	// A high byte of a covered channel writes the word into the RAM.
	assign ram_we    = in_beat && pos_payload && pos_q[0] && ch_ok;
	assign ram_waddr = ch[CH_W-1:0];

	// Checksum test on the final byte.
	assign good_frame = in_beat && pos_last && !fault_q
		&& ((16'hFFFF - sum_q) == word);

	// Byte parser.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			low_q   <= '0;
			fault_q <= 1'b0;
		end else if (in_beat) begin
			if (pos_q == '0) begin
				if (b == 8'(FRAME_BYTES)) begin
					pos_q   <= POS_W'(1);
					sum_q   <= VW'(FRAME_BYTES);
					fault_q <= 1'b0;
				end
			end else if (pos_q == POS_W'(1) && b != rcsfr_pkg::CMD_BYTE) begin
				// Resynchronize: another length byte keeps the parser armed.
				if (b == 8'(FRAME_BYTES)) begin
					pos_q   <= POS_W'(1);
					sum_q   <= VW'(FRAME_BYTES);
					fault_q <= 1'b0;
				end else begin
					pos_q <= '0;
				end
			end else if (pos_q < POS_W'(FRAME_BYTES - 2)) begin
				sum_q <= sum_q + VW'(b);
				if (pos_payload) begin
					if (!pos_q[0]) begin
						low_q <= b;
					end else if (ch_ok && word_bad) begin
						fault_q <= 1'b1;
					end
				end
				pos_q <= pos_q + POS_W'(1);
			end else if (pos_q == POS_W'(FRAME_BYTES - 2)) begin
				low_q <= b;
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
			end
		end
	end

	// Emission sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcsfr_pkg::EM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM read and handshake outputs.
	always_comb begin
		state_d       = state_q;
		ram_re        = 1'b0;
		ram_raddr     = '0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			rcsfr_pkg::EM_IDLE: begin
				s_axis_tready = 1'b1;
				if (good_frame) begin
					ram_re  = 1'b1;
					state_d = rcsfr_pkg::EM_LOAD;
				end
			end
			rcsfr_pkg::EM_LOAD: begin
				state_d = rcsfr_pkg::EM_SHOW;
			end
			rcsfr_pkg::EM_SHOW: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					if (idx_last) begin
						state_d = rcsfr_pkg::EM_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + CH_W'(1);
						state_d   = rcsfr_pkg::EM_LOAD;
					end
				end
			end
			default: begin
				state_d = rcsfr_pkg::EM_IDLE;
			end
		endcase
	end

	// Channel counter of the burst.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (good_frame) begin
			idx_q <= '0;
		end else if (out_beat && !idx_last) begin
			idx_q <= idx_q + CH_W'(1);
		end
	end

	// Output register takes the RAM word in the EM_LOAD state that follows the read.
	always_ff @(posedge clk) begin
		if (state_q == rcsfr_pkg::EM_LOAD) begin
			value_q <= ram_rdata;
		end
	end

	assign m_axis_tdata = {4'b0000, value_q, rcsfr_pkg::INDEX_W'(idx_q)};
	assign m_axis_tlast = idx_last;

	// Channel word store; writes happen only while parsing, reads only in a burst.
	rcsfr_ram #(
		.WIDTH(VW),
		.DEPTH(CHANNELS)
	) u_chan_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The parser is held while a burst is in flight.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted during a result burst");

	// A RAM write never coincides with a burst read.
	a_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == rcsfr_pkg::EM_IDLE))
		else $error("channel RAM written outside the idle state");

	// The output register loads only after a RAM read was issued.
	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcsfr_pkg::EM_LOAD) |-> $past(ram_re))
		else $error("output register loaded without a RAM read");

	// The final beat of a burst returns the sequencer to idle.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && m_axis_tlast) |=> (state_q == rcsfr_pkg::EM_IDLE))
		else $error("burst did not end after the last beat");

	// A non-final beat advances to the next channel.
	a_next_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && !m_axis_tlast) |=> (idx_q == $past(idx_q) + CH_W'(1)))
		else $error("channel index did not advance");

endmodule

`default_nettype wire

// File: hdl/rcsfr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the channel words of the frame receiver.
`default_nettype none

module rcsfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 14
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
